@@ src/sblur5_pkg.sv @@
// Shared types, constants and arithmetic helpers for the separable 5x5 blur.
`default_nettype none

package sblur5_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int CHAN_W    = 8;
	localparam int PIX_W     = 3 * CHAN_W;
	localparam int SUM_W     = 12;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int CFG_W     = 12;
	localparam int WCMP_W    = 14;
	localparam int SLOTS     = 4;
	localparam int PAD       = 2;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
	localparam logic [2:0]       ROW_SAT    = 3'd4;
	localparam logic [12:0]      DIV10_MUL  = 13'd6554;

	typedef logic [PIX_W-1:0]     pix_t;
	typedef logic [3*SUM_W-1:0]   psum_t;
	typedef logic [COL_W-1:0]     col_t;
	typedef logic [SLOTS*PIX_W-1:0] rword_t;

	typedef struct packed {
		logic emit;
		logic row_end;
		logic frame_end;
		logic run_last;
	} tag_t;

	// 1-2-4-2-1 weighted sum per channel, no division
	function automatic psum_t tap5(pix_t a, pix_t b, pix_t c, pix_t d, pix_t e);
		psum_t r;
		r = '0;
		for (int k = 0; k < 3; k++) begin
			r[SUM_W*k +: SUM_W] = SUM_W'(a[CHAN_W*k +: CHAN_W])
				+ {3'b0, b[CHAN_W*k +: CHAN_W], 1'b0}
				+ {2'b0, c[CHAN_W*k +: CHAN_W], 2'b0}
				+ {3'b0, d[CHAN_W*k +: CHAN_W], 1'b0}
				+ SUM_W'(e[CHAN_W*k +: CHAN_W]);
		end
		return r;
	endfunction

	// floor(s / 10) per channel via reciprocal; exact for s <= 2550
	function automatic pix_t div10(psum_t s);
		pix_t        r;
		logic [24:0] p;
		r = '0;
		for (int k = 0; k < 3; k++) begin
			p = 25'(s[SUM_W*k +: SUM_W]) * 25'(DIV10_MUL);
			r[CHAN_W*k +: CHAN_W] = p[23:16];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/separable_blur_5x5_zero_pad_unit.sv @@
// Top level: streaming separable 5x5 blur with zero padding over a row-store memory.
// A request is accepted into the item register; its results then pass through s1,
//   s2 and s3 to the output register.
// Throughput: one request per cycle while the output accepts data; the last pixel of a
//   row makes up to three row-store updates and holds off the next request until all issue.
// Reset (arst_n low, async): counts, pixel window and pipeline valids clear, width
//   returns to 640. The row store is not cleared; row count masks stale rows.
`default_nettype none

module separable_blur_5x5_zero_pad_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration: image_width
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [sblur5_pkg::CFG_W-1:0]   cfg_data,
	// input pixels
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [23:0]                    s_tdata,  // blue, green, red
	input  wire logic [1:0]                     s_tuser,  // frame_start, flush
	// blurred pixels
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [23:0]                         m_tdata,  // out_blue, out_green, out_red
	output logic [1:0]                          m_tuser,  // row_end, frame_end
	output logic                                m_tlast   // run_last
);
	import sblur5_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	// ---------------------------------------------------------------
	// Config register and effective (clamped) width
	// ---------------------------------------------------------------
	logic [CFG_W-1:0]  width_q;
	logic [WCMP_W-1:0] w_ext;
	logic [WCMP_W-1:0] w_eff;

	assign cfg_ready = 1'b1;
	assign w_ext     = WCMP_W'(width_q);

	always_comb begin
		priority if (w_ext == '0)
			w_eff = WCMP_W'(1);
		else if (w_ext > WCMP_W'(MAX_WIDTH))
			w_eff = WCMP_W'(MAX_WIDTH);
		else
			w_eff = w_ext;
	end

	// ---------------------------------------------------------------
	// Frame state: pixel window (index 0 newest), counts, store slot
	// ---------------------------------------------------------------
	pix_t       win_q [4];
	col_t       col_q;
	logic [2:0] rc_q;
	logic [1:0] slot_q;
	logic [1:0] frc_q;

	// Item register: one request held while its store updates issue
	logic       a_valid_q;
	pix_t       a_seq_q [5];
	col_t       a_col_q;
	logic [1:0] a_slot_q;
	logic [2:0] a_rc_q;
	logic       a_emit_q;
	logic       a_last_q;
	logic       a_flend_q;
	logic [1:0] a_j_q;
	logic [1:0] a_jmax_q;

	// Request decode; frame_start clears state ahead of the item
	logic       in_fire;
	logic       in_fs;
	logic       in_fl;
	pix_t       in_cur;
	pix_t       eff_win [4];
	col_t       eff_c;
	logic [2:0] eff_rc;
	logic [1:0] eff_frc;
	logic       in_ignore;
	logic       in_last;
	logic       in_has_ops;
	logic [1:0] in_j0;

	assign in_fs  = s_tuser[0];
	assign in_fl  = s_tuser[1];
	assign in_cur = in_fl ? '0 : s_tdata;

	always_comb begin
		for (int i = 0; i < 4; i++)
			eff_win[i] = in_fs ? '0 : win_q[i];
	end

	assign eff_c      = in_fs ? '0 : col_q;
	assign eff_rc     = in_fs ? '0 : rc_q;
	assign eff_frc    = in_fs ? '0 : frc_q;
	// past the second flush row, extra flush items are dropped
	assign in_ignore  = !in_fs && in_fl && (eff_frc >= 2'(PAD));
	assign in_last    = WCMP_W'(eff_c) >= (w_eff - WCMP_W'(1));
	assign in_has_ops = in_last || (eff_c >= COL_W'(PAD));
	// left-edge columns: first horizontal position is not yet in the image
	assign in_j0      = (eff_c >= COL_W'(PAD)) ? 2'd0 : (2'(PAD) - eff_c[1:0]);

	// ---------------------------------------------------------------
	// Op issue from the item register: while s1 is ready, one store update per cycle
	// ---------------------------------------------------------------
	pix_t   op_win [5];
	psum_t  op_sum;
	col_t   op_x;
	tag_t   op_tag;
	logic   s1_ready;
	logic   a_fire;
	logic   a_done;

	always_comb begin
		unique case (a_j_q)
			2'd0: begin
				for (int i = 0; i < 5; i++)
					op_win[i] = a_seq_q[i];
			end
			2'd1: begin
				for (int i = 0; i < 4; i++)
					op_win[i] = a_seq_q[i+1];
				op_win[4] = '0;
			end
			default: begin
				for (int i = 0; i < 3; i++)
					op_win[i] = a_seq_q[i+2];
				op_win[3] = '0;
				op_win[4] = '0;
			end
		endcase
	end

	assign op_sum = tap5(op_win[0], op_win[1], op_win[2], op_win[3], op_win[4]);
	assign op_x   = a_col_q + COL_W'(a_j_q) - COL_W'(PAD);

	assign op_tag.emit      = a_emit_q;
	assign op_tag.row_end   = a_last_q && (a_j_q == 2'd2);
	assign op_tag.frame_end = a_last_q && (a_j_q == 2'd2) && a_flend_q;
	assign op_tag.run_last  = (a_j_q == a_jmax_q);

	assign a_fire   = a_valid_q && s1_ready;
	assign a_done   = a_fire && (a_j_q == a_jmax_q);
	assign s_tready = !a_valid_q || a_done;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RST;
			for (int i = 0; i < 4; i++)
				win_q[i] <= '0;
			col_q     <= '0;
			rc_q      <= '0;
			slot_q    <= '0;
			frc_q     <= '0;
			a_valid_q <= 1'b0;
			a_j_q     <= '0;
		end else begin
			if (cfg_valid)
				width_q <= cfg_data;
			if (in_fire && !in_ignore) begin
				if (in_last) begin
					for (int i = 0; i < 4; i++)
						win_q[i] <= '0;
					col_q  <= '0;
					rc_q   <= (eff_rc < ROW_SAT) ? eff_rc + 3'd1 : eff_rc;
					slot_q <= slot_q + 2'd1;
					frc_q  <= (in_fl && eff_frc < 2'(PAD)) ? eff_frc + 2'd1 : eff_frc;
				end else begin
					win_q[0] <= in_cur;
					for (int i = 1; i < 4; i++)
						win_q[i] <= eff_win[i-1];
					col_q <= eff_c + COL_W'(1);
					rc_q  <= eff_rc;
					frc_q <= eff_frc;
				end
			end
			// item register: load on request, else step through its ops
			if (in_fire) begin
				a_valid_q <= !in_ignore && in_has_ops;
				a_j_q     <= in_j0;
			end else if (a_fire) begin
				if (a_j_q == a_jmax_q)
					a_valid_q <= 1'b0;
				else
					a_j_q <= a_j_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			a_seq_q[0] <= eff_win[3];
			a_seq_q[1] <= eff_win[2];
			a_seq_q[2] <= eff_win[1];
			a_seq_q[3] <= eff_win[0];
			a_seq_q[4] <= in_cur;
			a_col_q    <= eff_c;
			a_slot_q   <= slot_q;
			a_rc_q     <= eff_rc;
			a_emit_q   <= eff_rc >= 3'(PAD);
			a_last_q   <= in_last;
			a_flend_q  <= in_fl && (eff_frc == 2'(PAD - 1));
			a_jmax_q   <= in_last ? 2'd2 : 2'd0;
		end
	end

	// ---------------------------------------------------------------
	// Row store: one word per column holds all four row slots.
	// Read at issue, merged and written back in s1 (read-modify-write).
	// ---------------------------------------------------------------
	rword_t          row_mem [MAX_WIDTH];
	rword_t          rd_s1;
	logic            s1_valid;
	logic [AW-1:0]   s1_addr;
	psum_t           s1_sum;
	logic [1:0]      s1_slot;
	logic [2:0]      s1_rc;
	tag_t            s1_tag;
	logic            s1_fire;
	logic            s1_wr;

	// last write, forwarded when the next read hit the same column
	logic            wlast_valid_q;
	logic [AW-1:0]   wlast_addr_q;
	rword_t          wlast_data_q;

	logic            fwd_hit;
	rword_t          s1_word;
	pix_t            s1_words [SLOTS];
	pix_t            s1_h;
	rword_t          s1_new;
	pix_t            s1_col [4];
	logic [1:0]      s1_ks [4];

	logic            s2_ready;

	assign fwd_hit = wlast_valid_q && (wlast_addr_q == s1_addr);
	assign s1_word = fwd_hit ? wlast_data_q : rd_s1;
	assign s1_h    = div10(s1_sum);

	always_comb begin
		s1_new = s1_word;
		for (int k = 0; k < SLOTS; k++) begin
			s1_words[k] = s1_word[k*PIX_W +: PIX_W];
			if (2'(k) == s1_slot)
				s1_new[k*PIX_W +: PIX_W] = s1_h;
		end
		// rows above the current one, masked until the frame has them
		for (int k = 1; k <= 4; k++) begin
			s1_ks[4-k]  = s1_slot - 2'(k);
			s1_col[4-k] = (s1_rc >= 3'(k)) ? s1_words[s1_ks[4-k]] : '0;
		end
	end

	assign s1_fire  = s1_valid && (!s1_tag.emit || s2_ready);
	assign s1_wr    = s1_fire;
	assign s1_ready = !s1_valid || s1_fire;

	always_ff @(posedge clk) begin
		if (a_fire)
			rd_s1 <= row_mem[AW'(op_x)];
		if (s1_wr)
			row_mem[s1_addr] <= s1_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid      <= 1'b0;
			wlast_valid_q <= 1'b0;
		end else begin
			if (s1_ready)
				s1_valid <= a_valid_q;
			if (s1_wr)
				wlast_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (a_fire) begin
			s1_addr <= AW'(op_x);
			s1_sum  <= op_sum;
			s1_slot <= a_slot_q;
			s1_rc   <= a_rc_q;
			s1_tag  <= op_tag;
		end
		if (s1_wr) begin
			wlast_addr_q <= s1_addr;
			wlast_data_q <= s1_new;
		end
	end

	// ---------------------------------------------------------------
	// Vertical pass: s2 sums the column, s3 divides, then output register
	// ---------------------------------------------------------------
	logic   s2_valid;
	pix_t   s2_col [4];
	pix_t   s2_h;
	tag_t   s2_tag;
	psum_t  s2_sum;

	logic   s3_valid;
	psum_t  s3_sum;
	tag_t   s3_tag;
	logic   s3_ready;

	logic   out_ready;
	pix_t   m_data_q;
	tag_t   m_tag_q;
	logic   m_valid_q;

	assign s2_sum    = tap5(s2_col[0], s2_col[1], s2_col[2], s2_col[3], s2_h);
	assign out_ready = !m_valid_q || m_tready;
	assign s3_ready  = !s3_valid || out_ready;
	assign s2_ready  = !s2_valid || s3_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid  <= 1'b0;
			s3_valid  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s2_ready)
				s2_valid <= s1_valid && s1_tag.emit;
			if (s3_ready)
				s3_valid <= s2_valid;
			if (out_ready)
				m_valid_q <= s3_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready) begin
			for (int i = 0; i < 4; i++)
				s2_col[i] <= s1_col[i];
			s2_h   <= s1_h;
			s2_tag <= s1_tag;
		end
		if (s3_ready) begin
			s3_sum <= s2_sum;
			s3_tag <= s2_tag;
		end
		if (out_ready) begin
			m_data_q <= div10(s3_sum);
			m_tag_q  <= s3_tag;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = {m_tag_q.frame_end, m_tag_q.row_end};
	assign m_tlast  = m_tag_q.run_last;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		a_valid_q |-> (a_j_q <= a_jmax_q))
		else $error("op index past last op of item");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> a_valid_q)
		else $error("input stalled with empty item register");

	a_fwd_track: assert property (@(posedge clk) disable iff (!arst_n)
		s1_wr |=> (wlast_valid_q && wlast_addr_q == $past(s1_addr)))
		else $error("forwarding register missed a row-store write");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_tag_q.frame_end) |-> (m_tag_q.row_end && m_tag_q.run_last))
		else $error("frame end without row end and run last");

	a_row_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rc_q <= ROW_SAT)
		else $error("row count past saturation");

endmodule

`default_nettype wire
